// ----- design/ggc_pkg.sv -----
// Shared widths and the command bundle for the graph coloring block.
`default_nettype none
package ggc_pkg;

	localparam int VERTEX_W = 6;
	localparam int COLOR_W  = 7;
	localparam int CMD_W    = 1;

	localparam logic [CMD_W-1:0] CMD_EDGE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_RUN  = 1'b1;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_cmd_t;

endpackage
`default_nettype wire

// ----- design/ggc_adj_store.sv -----
// Adjacency row memory with per-row valid bits so that all rows clear at once.
`default_nettype none
module ggc_adj_store #(
	parameter int ROWS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ggc_pkg::mem_cmd_t         cmd,
	input  logic [$clog2(ROWS)-1:0]   raddr,
	input  logic [$clog2(ROWS)-1:0]   waddr,
	input  logic [ROWS-1:0]           wdata,
	output logic [ROWS-1:0]           rdata
);
	import ggc_pkg::*;

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] row_valid_q;
	logic [ROWS-1:0] rdata_q;
	logic            rvalid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (cmd.clr) begin
				row_valid_q <= '0;
			end else if (cmd.wr) begin
				row_valid_q[waddr] <= 1'b1;
			end
			if (cmd.rd) begin
				rvalid_q <= row_valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

// ----- design/ggc_color_store.sv -----
// Per-vertex color memory, one write and one registered read port.
`default_nettype none
module ggc_color_store #(
	parameter int ROWS = 64
) (
	input  logic                          clk,
	input  ggc_pkg::mem_cmd_t             cmd,
	input  logic [$clog2(ROWS)-1:0]       raddr,
	input  logic [$clog2(ROWS)-1:0]       waddr,
	input  logic [ggc_pkg::COLOR_W-1:0]   wdata,
	output logic [ggc_pkg::COLOR_W-1:0]   rdata
);
	import ggc_pkg::*;

	logic [COLOR_W-1:0] mem [ROWS];
	logic [COLOR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/greedy_graph_coloring.sv -----
// Top level: edge loader, first-fit coloring sequencer and result register.
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid, cfg_ready | cfg_data (vertex count)
//  in      | in        | in_valid, in_stall   | command, first_vertex, second_vertex
//  out     | out       | out_valid, out_stall | vertex, color, colors_used, last
// An edge beat is accepted in idle, reads one adjacency row, then writes it back;
// a self loop is dropped in its accept cycle.
// For each vertex a run reads its adjacency row, serially scans the color memory
// over lower vertices, then searches for the first free color and emits it.
// Reset and each finished run clear the adjacency rows at once through valid bits.
// A stalled result holds the sequencer; the next input beat waits until idle.
`default_nettype none
module greedy_graph_coloring #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ggc_pkg::COLOR_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ggc_pkg::CMD_W-1:0]      command,
	input  logic [ggc_pkg::VERTEX_W-1:0]   first_vertex,
	input  logic [ggc_pkg::VERTEX_W-1:0]   second_vertex,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ggc_pkg::VERTEX_W-1:0]   vertex,
	output logic [ggc_pkg::COLOR_W-1:0]    color,
	output logic [ggc_pkg::COLOR_W-1:0]    colors_used,
	output logic                           last
);
	import ggc_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_EDGE_RD = 7'b0000010,
		S_EDGE_WR = 7'b0000100,
		S_ROW     = 7'b0001000,
		S_SCAN    = 7'b0010000,
		S_SEARCH  = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [COLOR_W-1:0]      vcount_q;
	logic [AW-1:0]           i_q;
	logic [AW-1:0]           n_last_q;
	logic [AW-1:0]           j_q;
	logic [AW-1:0]           c_q;
	logic [AW-1:0]           hi_q;
	logic [AW-1:0]           lo_q;
	logic [MAX_VERTICES-1:0] blocked_q;
	logic                    hit_s1;
	logic [COLOR_W-1:0]      color_q;
	logic [COLOR_W-1:0]      maxc_q;

	logic                    out_valid_q;
	logic [VERTEX_W-1:0]     vertex_q;
	logic [COLOR_W-1:0]      color_out_q;
	logic [COLOR_W-1:0]      used_q;
	logic                    last_q;

	mem_cmd_t                adj_cmd;
	mem_cmd_t                col_cmd;
	logic [AW-1:0]           adj_raddr;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic [MAX_VERTICES-1:0] adj_rdata;
	logic [COLOR_W-1:0]      col_rdata;
	logic [COLOR_W-1:0]      col_m1;
	logic [COLOR_W-1:0]      color_nx;
	logic [COLOR_W-1:0]      eff_last;
	logic                    in_fire;
	logic                    edge_ok;
	logic                    emit_go;
	logic                    run_done;
	logic [AW-1:0]           hi_nx;
	logic [AW-1:0]           lo_nx;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;

	assign edge_ok = ({1'b0, first_vertex} < (VERTEX_W + 1)'(MAX_VERTICES))
		&& ({1'b0, second_vertex} < (VERTEX_W + 1)'(MAX_VERTICES))
		&& (first_vertex != second_vertex);
	assign hi_nx = (first_vertex > second_vertex) ? first_vertex[AW-1:0]
		: second_vertex[AW-1:0];
	assign lo_nx = (first_vertex > second_vertex) ? second_vertex[AW-1:0]
		: first_vertex[AW-1:0];

	always_comb begin
		if (vcount_q == '0) begin
			eff_last = '0;
		end else if (vcount_q > COLOR_W'(MAX_VERTICES)) begin
			eff_last = COLOR_W'(MAX_VERTICES - 1);
		end else begin
			eff_last = vcount_q - COLOR_W'(1);
		end
	end

	assign color_nx = COLOR_W'(c_q) + COLOR_W'(1);
	assign col_m1   = col_rdata - COLOR_W'(1);
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign run_done = emit_go && (i_q == n_last_q);

	always_comb begin
		adj_cmd     = '0;
		adj_cmd.rd  = (state_q == S_EDGE_RD) || (state_q == S_ROW);
		adj_cmd.wr  = (state_q == S_EDGE_WR);
		adj_cmd.clr = run_done;
		adj_raddr   = (state_q == S_ROW) ? i_q : hi_q;
		adj_wdata   = adj_rdata | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << lo_q);
		col_cmd     = '0;
		col_cmd.rd  = (state_q == S_SCAN) && (j_q != i_q);
		col_cmd.wr  = (state_q == S_SEARCH) && !blocked_q[c_q];
	end

	ggc_adj_store #(
		.ROWS(MAX_VERTICES)
	) u_adj (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (adj_cmd),
		.raddr (adj_raddr),
		.waddr (hi_q),
		.wdata (adj_wdata),
		.rdata (adj_rdata)
	);

	ggc_color_store #(
		.ROWS(MAX_VERTICES)
	) u_col (
		.clk  (clk),
		.cmd  (col_cmd),
		.raddr(j_q),
		.waddr(i_q),
		.wdata(color_nx),
		.rdata(col_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			vcount_q <= COLOR_W'(64);
			hit_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			hit_s1 <= (state_q == S_SCAN) && (j_q != i_q) && adj_rdata[j_q];
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (command == CMD_RUN) begin
							state_q <= S_ROW;
						end else if (edge_ok) begin
							state_q <= S_EDGE_RD;
						end
					end
				end
				S_EDGE_RD: state_q <= S_EDGE_WR;
				S_EDGE_WR: state_q <= S_IDLE;
				S_ROW:     state_q <= S_SCAN;
				S_SCAN: begin
					if (j_q == i_q) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (!blocked_q[c_q]) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= run_done ? S_IDLE : S_ROW;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				hi_q     <= hi_nx;
				lo_q     <= lo_nx;
				i_q      <= '0;
				n_last_q <= eff_last[AW-1:0];
				maxc_q   <= COLOR_W'(1);
			end
			S_ROW: begin
				j_q       <= '0;
				c_q       <= '0;
				blocked_q <= '0;
			end
			S_SCAN: begin
				if (j_q != i_q) begin
					j_q <= j_q + AW'(1);
				end
			end
			S_SEARCH: begin
				if (!blocked_q[c_q]) begin
					color_q <= color_nx;
					if (color_nx > maxc_q) begin
						maxc_q <= color_nx;
					end
				end else begin
					c_q <= c_q + AW'(1);
				end
			end
			S_EMIT: begin
				if (emit_go && !run_done) begin
					i_q <= i_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
		if (hit_s1) begin
			blocked_q[col_m1[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			vertex_q    <= VERTEX_W'(i_q);
			color_out_q <= color_q;
			used_q      <= maxc_q;
			last_q      <= run_done;
		end
	end

	assign out_valid   = out_valid_q;
	assign vertex      = vertex_q;
	assign color       = color_out_q;
	assign colors_used = used_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (c_q <= i_q))
		else $error("free color search ran past vertex index");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (j_q <= i_q))
		else $error("neighbor scan ran past vertex index");
	a_max_color: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (maxc_q >= color_q) && (color_q <= COLOR_W'(i_q) + 7'd1))
		else $error("color bookkeeping out of range");
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |=> (state_q == S_IDLE) && out_valid_q && last_q)
		else $error("final result did not end the run");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_greedy_graph_coloring.sv -----
// Testbench for greedy_graph_coloring: directed and random graphs checked against a first-fit predictor.
`timescale 1ns / 100ps
module tb_greedy_graph_coloring;
	import ggc_pkg::*;

	localparam int MAX_VERTICES = 64;
	localparam int DRAIN_CYCLES = 16;
	localparam int TAIL_CYCLES  = 200;
	localparam int PHASE_BEATS  = 2;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [VERTEX_W-1:0] first_vertex;
		logic [VERTEX_W-1:0] second_vertex;
	} graph_beat_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] vertex;
		logic [COLOR_W-1:0]  color;
		logic [COLOR_W-1:0]  colors_used;
		logic                last;
	} vertex_color_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [COLOR_W-1:0]  cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    command = CMD_EDGE;
	logic [VERTEX_W-1:0] first_vertex = '0;
	logic [VERTEX_W-1:0] second_vertex = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [VERTEX_W-1:0] vertex;
	logic [COLOR_W-1:0]  color;
	logic [COLOR_W-1:0]  colors_used;
	logic                last;

	graph_beat_t   pending_beats[$];
	vertex_color_t expected_colors[$];
	int            beats_outstanding = 0;
	int            mismatches = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;

	logic [MAX_VERTICES-1:0] adjacency [MAX_VERTICES] = '{default: '0};
	logic [COLOR_W-1:0]      assigned_color [MAX_VERTICES] = '{default: '0};
	logic [COLOR_W-1:0]      vertex_count_set = 7'd64;

	greedy_graph_coloring #(
		.MAX_VERTICES(MAX_VERTICES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.first_vertex(first_vertex),
		.second_vertex(second_vertex),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.vertex(vertex),
		.color(color),
		.colors_used(colors_used),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic void color_graph();
		int                      n;
		int                      v;
		int                      u;
		int                      k;
		logic [MAX_VERTICES-1:0] taken;
		logic [COLOR_W-1:0]      shade;
		logic [COLOR_W-1:0]      highest;
		vertex_color_t           result;
		if (vertex_count_set == 0)
			n = 1;
		else if (vertex_count_set > MAX_VERTICES)
			n = MAX_VERTICES;
		else
			n = int'(vertex_count_set);
		highest = 7'd1;
		for (v = 0; v < n; v++) begin
			taken = '0;
			for (u = 0; u < v; u++)
				if (adjacency[v][u])
					taken[assigned_color[u] - 1] = 1'b1;
			k = 0;
			while (k < MAX_VERTICES - 1 && taken[k])
				k++;
			shade = COLOR_W'(k + 1);
			assigned_color[v] = shade;
			if (shade > highest)
				highest = shade;
			result.vertex = VERTEX_W'(v);
			result.color = shade;
			result.colors_used = highest;
			result.last = (v == n - 1);
			expected_colors.push_back(result);
		end
		for (v = 0; v < MAX_VERTICES; v++)
			adjacency[v] = '0;
	endfunction

	task automatic queue_beat(input logic [CMD_W-1:0] cmd, input int a, input int b);
		graph_beat_t beat;
		beat.command = cmd;
		beat.first_vertex = a[VERTEX_W-1:0];
		beat.second_vertex = b[VERTEX_W-1:0];
		pending_beats.push_back(beat);
		beats_outstanding++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (beats_outstanding != 0 || expected_colors.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [COLOR_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		vertex_count_set = value;
	endtask

	always @(posedge clk) begin : drive_beats
		graph_beat_t beat;
		// hold while stalled
		if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				beats_outstanding--;
				if (command == CMD_RUN) begin
					color_graph();
				end else begin
					adjacency[first_vertex][second_vertex] = 1'b1;
					adjacency[second_vertex][first_vertex] = 1'b1;
				end
			end
			if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				beat = pending_beats.pop_front();
				in_valid <= 1'b1;
				command <= beat.command;
				first_vertex <= beat.first_vertex;
				second_vertex <= beat.second_vertex;
			end else
				in_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		vertex_color_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_colors.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected beat: vertex %0d color %0d colors_used %0d last %0b",
						vertex, color, colors_used, last);
			end else begin
				want = expected_colors.pop_front();
				if (vertex !== want.vertex || color !== want.color ||
						colors_used !== want.colors_used || last !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: got vertex %0d color %0d colors_used %0d last %0b, %s %0d %0d %0d %0b",
							vertex, color, colors_used, last, "expected",
							want.vertex, want.color, want.colors_used, want.last);
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin : stimulus
		int p;
		int cnt;
		int n_eff;
		int kind;
		int m;
		int a;
		int b;
		int phase_beats;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// triangle, self loop, duplicate and top vertices at the reset count
		queue_beat(CMD_EDGE, 0, 1);
		queue_beat(CMD_EDGE, 1, 2);
		queue_beat(CMD_EDGE, 2, 0);
		queue_beat(CMD_EDGE, 5, 5);
		queue_beat(CMD_EDGE, 63, 62);
		queue_beat(CMD_EDGE, 0, 63);
		queue_beat(CMD_EDGE, 1, 0);
		queue_beat(CMD_RUN, 63, 63);

		write_vertex_count(7'd0);
		queue_beat(CMD_EDGE, 0, 0);
		queue_beat(CMD_EDGE, 0, 1);
		queue_beat(CMD_RUN, 21, 42);

		write_vertex_count(7'd2);
		queue_beat(CMD_EDGE, 1, 0);
		queue_beat(CMD_EDGE, 1, 40);
		queue_beat(CMD_RUN, 42, 21);

		// empty graph after a run: checks the clear
		write_vertex_count(7'd127);
		queue_beat(CMD_RUN, 0, 63);

		for (p = 0; p < 8; p++) begin
			case (p)
				1: cnt = 64;
				4: cnt = 127;
				6: cnt = 65;
				7: cnt = 1;
				default: cnt = $urandom_range(2, 16);
			endcase
			write_vertex_count(cnt[COLOR_W-1:0]);
			send_idle_pct = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 31 : 0;
			recv_stall_pct = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 31 : 0;
			n_eff = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
			phase_beats = 0;
			while (phase_beats < PHASE_BEATS) begin
				kind = $urandom_range(0, 9);
				if (kind >= 1 && kind <= 2) begin
					m = (n_eff < 8) ? n_eff : 8;
					for (a = 0; a < m; a++)
						for (b = a + 1; b < m; b++) begin
							queue_beat(CMD_EDGE, b, a);
							phase_beats++;
						end
				end else if (kind > 2) begin
					m = $urandom_range(1, 12);
					repeat (m) begin
						a = $urandom_range(0, n_eff - 1);
						b = $urandom_range(0, n_eff - 1);
						if ($urandom_range(0, 7) == 0)
							b = $urandom_range(0, 63);
						queue_beat(CMD_EDGE, a, b);
						phase_beats++;
					end
				end
				queue_beat(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
				phase_beats++;
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_colors.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- greedy_graph_coloring.f -----
design/ggc_pkg.sv
design/ggc_adj_store.sv
design/ggc_color_store.sv
design/greedy_graph_coloring.sv
tb/sv/tb_greedy_graph_coloring.sv
